[sv/crd_pkg.sv]
// Shared types, constants and the CRC-32 byte table for the record deframer.
// No dependencies; the modules and the bench refer to this package by scoped names.
package crd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned HDR_BYTES      = 12;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

  localparam int unsigned REG_FLEN   = 0;
  localparam int unsigned REG_CRC_EN = 1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [31:0] TAG_MAGIC = 32'h4341_5053;
  localparam logic [31:0] TAG_DATA  = 32'h4441_5441;
  localparam logic [31:0] TAG_TRCK  = 32'h5452_434B;

  localparam int unsigned NUM_TAGS = 11;
  localparam logic [31:0] KNOWN_TAGS [NUM_TAGS] = '{
    32'h4341_5053, 32'h494E_464F, 32'h494D_4745, 32'h4441_5441,
    32'h5452_434B, 32'h4354_4549, 32'h4354_4558, 32'h4455_4D50,
    32'h434F_4D4D, 32'h5445_5854, 32'h5553_4552
  };

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_TRUNC     = 3'd3,
    ST_SHORT     = 3'd4
  } status_t;

  // Record event passed from the parser to the statistics stage
  typedef struct packed {
    status_t     status;
    logic [31:0] rtype;
    logic [31:0] rlen;
    logic [31:0] hoff;
  } ev_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_tab_gen();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_tab_gen();

  function automatic logic tag_known(input logic [31:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (KNOWN_TAGS[i] == t) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[sv/crd_byte_if.sv]
// Input byte channel: valid/ready handshake carrying one file byte per word.
// Depends on nothing.
interface crd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[sv/crd_rec_if.sv]
// Result channel: valid/ready handshake carrying one record report per word.
// Depends on nothing.
interface crd_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] record_type;
  logic [31:0] record_length;
  logic [31:0] rec_offset;
  logic [15:0] record_number;
  logic        type_known;
  logic [15:0] data_count;
  logic [15:0] track_count;
  logic [15:0] unknown_count;
  logic [31:0] payload_total;

  modport source (output valid, output status, output record_type, output record_length,
                  output rec_offset, output record_number, output type_known,
                  output data_count, output track_count, output unknown_count,
                  output payload_total, input ready);
  modport sink   (input valid, input status, input record_type, input record_length,
                  input rec_offset, input record_number, input type_known,
                  input data_count, input track_count, input unknown_count,
                  input payload_total, output ready);
endinterface

[sv/crd_front.sv]
// Header parser and payload CRC: takes one byte per cycle while the event queue is not full, emits record events.
// Depends on crd_pkg.
module crd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  input  logic [31:0]   flen,
  input  logic          crc_en,
  input  logic          q_full,
  output logic          ev_valid,
  output crd_pkg::ev_t  ev
);

  typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] off_r, off_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        first_r, first_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] hoff_r, hoff_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_step;
  logic        acc;
  logic        no_room;
  logic        past_end;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign crc_step = (crc_r >> 8) ^ crd_pkg::CRC_TABLE[crc_r[7:0] ^ in_byte];
  assign no_room  = ({1'b0, off_r} + 33'(crd_pkg::HDR_BYTES)) > {1'b0, flen};
  assign past_end = ({1'b0, off_r} + {1'b0, len_r} + 33'd1) > {1'b0, flen};

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    hcrc_nxt  = hcrc_r;
    hoff_nxt  = hoff_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    ev_valid  = 1'b0;
    ev.status = crd_pkg::ST_OK;
    ev.rtype  = type_r;
    ev.rlen   = len_r;
    ev.hoff   = hoff_r;
    if (acc) begin
      case (phase_r)
        PH_HDR: begin
          if (cnt_r == 4'd0 && no_room) begin
            phase_nxt = PH_DONE;
            if (off_r == 32'd0) begin
              ev_valid  = 1'b1;
              ev.status = crd_pkg::ST_SHORT;
              ev.rtype  = '0;
              ev.rlen   = '0;
              ev.hoff   = '0;
            end
          end else begin
            if (cnt_r < 4'd4) type_nxt = {type_r[23:0], in_byte};
            else if (cnt_r < 4'd8) len_nxt = {len_r[23:0], in_byte};
            else hcrc_nxt = {hcrc_r[23:0], in_byte};
            if (cnt_r == 4'd0) hoff_nxt = off_r;
            off_nxt = off_r + 32'd1;
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_r == 4'(crd_pkg::HDR_BYTES - 1)) begin
              cnt_nxt = 4'd0;
              if (first_r && type_r != crd_pkg::TAG_MAGIC) begin
                ev_valid  = 1'b1;
                ev.status = crd_pkg::ST_BAD_MAGIC;
                phase_nxt = PH_DONE;
              end else if (past_end) begin
                ev_valid  = 1'b1;
                ev.status = crd_pkg::ST_TRUNC;
                phase_nxt = PH_DONE;
              end else begin
                crc_nxt  = crd_pkg::ALL_ONES;
                left_nxt = len_r;
                if (len_r == 32'd0) begin
                  ev_valid  = 1'b1;
                  first_nxt = 1'b0;
                end else begin
                  phase_nxt = PH_PAY;
                end
              end
            end
          end
        end
        PH_PAY: begin
          crc_nxt  = crc_step;
          off_nxt  = off_r + 32'd1;
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            ev_valid  = 1'b1;
            first_nxt = 1'b0;
            phase_nxt = PH_HDR;
            if (crc_en && (crc_step ^ crd_pkg::ALL_ONES) != hcrc_r) begin
              ev.status = crd_pkg::ST_CRC_ERR;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      off_r   <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
      type_r  <= '0;
      len_r   <= '0;
      hcrc_r  <= '0;
      left_r  <= '0;
      crc_r   <= crd_pkg::ALL_ONES;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      hcrc_r  <= hcrc_nxt;
      left_r  <= left_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hoff_r <= hoff_nxt;
  end

endmodule

[sv/crd_fifo.sv]
// Short event queue between the parser and the statistics stage.
// Depends on crd_pkg.
module crd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  crd_pkg::ev_t  din,
  output logic          full,
  input  logic          pop,
  output crd_pkg::ev_t  dout,
  output logic          empty
);

  localparam int unsigned AW = crd_pkg::QUEUE_AW;

  crd_pkg::ev_t  mem_r [crd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(crd_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule

[sv/crd_back.sv]
// Statistics stage: classifies record types, keeps saturating counters and
// holds the output word register. Depends on crd_pkg and crd_rec_if.
module crd_back #(
  parameter int unsigned COUNT_BITS = crd_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  crd_pkg::ev_t  q_data,
  output logic          q_pop,
  crd_rec_if.source     out_ch
);

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  logic                  ov_r;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] ndata_r, ndata_nxt;
  logic [COUNT_BITS-1:0] ntrk_r, ntrk_nxt;
  logic [COUNT_BITS-1:0] nunk_r, nunk_nxt;
  logic [31:0]           tot_r, tot_nxt;
  logic [32:0]           sum;
  logic                  known;
  logic                  fin;
  crd_pkg::ev_t          ev_r;
  logic [COUNT_BITS-1:0] num_r;
  logic                  known_r;

  assign q_pop = !q_empty && (!ov_r || out_ch.ready);
  assign known = crd_pkg::tag_known(q_data.rtype);
  assign fin   = (q_data.status == crd_pkg::ST_OK) || (q_data.status == crd_pkg::ST_CRC_ERR);
  assign sum   = {1'b0, tot_r} + {1'b0, q_data.rlen};

  always_comb begin
    idx_nxt   = idx_r;
    ndata_nxt = ndata_r;
    ntrk_nxt  = ntrk_r;
    nunk_nxt  = nunk_r;
    tot_nxt   = tot_r;
    if (q_pop && fin) begin
      idx_nxt = (idx_r == CMAX) ? idx_r : idx_r + 1'b1;
      if (q_data.rtype == crd_pkg::TAG_DATA) begin
        ndata_nxt = (ndata_r == CMAX) ? ndata_r : ndata_r + 1'b1;
      end else if (q_data.rtype == crd_pkg::TAG_TRCK) begin
        ntrk_nxt = (ntrk_r == CMAX) ? ntrk_r : ntrk_r + 1'b1;
      end else if (!known) begin
        nunk_nxt = (nunk_r == CMAX) ? nunk_r : nunk_r + 1'b1;
      end
      tot_nxt = sum[32] ? crd_pkg::ALL_ONES : sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      idx_r   <= '0;
      ndata_r <= '0;
      ntrk_r  <= '0;
      nunk_r  <= '0;
      tot_r   <= '0;
    end else begin
      if (q_pop) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      idx_r   <= idx_nxt;
      ndata_r <= ndata_nxt;
      ntrk_r  <= ntrk_nxt;
      nunk_r  <= nunk_nxt;
      tot_r   <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r    <= q_data;
      num_r   <= idx_r;
      known_r <= known;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.status        = ev_r.status;
  assign out_ch.record_type   = ev_r.rtype;
  assign out_ch.record_length = ev_r.rlen;
  assign out_ch.rec_offset    = ev_r.hoff;
  assign out_ch.record_number = 16'(num_r);
  assign out_ch.type_known    = known_r;
  assign out_ch.data_count    = 16'(ndata_r);
  assign out_ch.track_count   = 16'(ntrk_r);
  assign out_ch.unknown_count = 16'(nunk_r);
  assign out_ch.payload_total = tot_r;

endmodule

[sv/container_record_deframer_crc.sv]
// Container record deframer: one file byte per cycle in, one word per record out.
// With an empty queue a record's event is written into the event queue, then into the output word register.
// Throughput: one byte per cycle, set by the byte-wide CRC table step in the parser;
// the 4-entry event queue absorbs output stalls, input stalls only when it fills.
// Synchronous active-low reset clears parser, queue and counters; length register 0,
// crc_check_enable 1. Depends on crd_pkg, crd_byte_if, crd_rec_if and submodules.
module container_record_deframer_crc #(
  parameter int unsigned COUNT_BITS = crd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  crd_byte_if.sink    in_ch,
  crd_rec_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]  fsize_r;
  logic         crc_en_r;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  logic         ev_valid;
  crd_pkg::ev_t ev;
  crd_pkg::ev_t q_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsize_r  <= '0;
      crc_en_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        1'(crd_pkg::REG_FLEN):   fsize_r  <= pwdata;
        1'(crd_pkg::REG_CRC_EN): crc_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      1'(crd_pkg::REG_FLEN):   prdata = fsize_r;
      1'(crd_pkg::REG_CRC_EN): prdata = {31'd0, crc_en_r};
      default:                 prdata = '0;
    endcase
  end

  crd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .flen      (fsize_r),
    .crc_en    (crc_en_r),
    .q_full    (q_full),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  crd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_valid),
    .din   (ev),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  crd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[bench/tb_container_record_deframer_crc.sv]
// Self-checking bench for container_record_deframer_crc: byte stream in, record reports out.
// Directed record table, then random record chains under several register settings.
// Depends on crd_pkg, crd_byte_if, crd_rec_if and the block itself.
module tb_container_record_deframer_crc;

  localparam logic [31:0] RECORD_TAGS [11] = '{
    32'h4341_5053, 32'h494E_464F, 32'h494D_4745, 32'h4441_5441,
    32'h5452_434B, 32'h4354_4549, 32'h4354_4558, 32'h4455_4D50,
    32'h434F_4D4D, 32'h5445_5854, 32'h5553_4552
  };

  typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_STOP} parse_ph_e;
  typedef enum logic [1:0] {CRC_GOOD, CRC_BAD, CRC_GIVEN} crc_mode_e;

  typedef struct packed {
    crd_pkg::status_t status;
    logic [31:0]      rtype;
    logic [31:0]      rlen;
    logic [31:0]      hoff;
    logic [15:0]      rnum;
    logic             known;
    logic [15:0]      ndata;
    logic [15:0]      ntrck;
    logic [15:0]      nunk;
    logic [31:0]      total;
  } rec_t;

  typedef struct packed {
    logic [31:0] rtype;
    logic [31:0] rlen;
    crc_mode_e   mode;
    logic [31:0] crc_val;
    logic [7:0]  fill;
    logic        typed;
    rec_t        want;
  } dir_row_t;

  typedef logic [7:0] byte_q_t [$];

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crd_byte_if in_ch ();
  crd_rec_if  out_ch ();

  container_record_deframer_crc i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // deframer state as seen from outside
  parse_ph_e   pr_phase  = PH_HDR;
  logic [31:0] pr_offset = '0;
  int          pr_hcount = 0;
  logic [31:0] pr_type   = '0;
  logic [31:0] pr_len    = '0;
  logic [31:0] pr_crc    = '0;
  logic [31:0] pr_left   = '0;
  logic [31:0] pr_run    = crd_pkg::ALL_ONES;
  logic [15:0] pr_index  = '0;
  logic [15:0] pr_ndata  = '0;
  logic [15:0] pr_ntrck  = '0;
  logic [15:0] pr_nunk   = '0;
  logic [31:0] pr_total  = '0;
  logic [31:0] cfg_flen   = '0;
  logic        cfg_crc_on = 1'b1;

  rec_t pending_reports [$];
  rec_t head_rec;
  int   fail_count = 0;
  int   bytes_sent = 0;
  bit   no_gaps    = 1'b0;
  bit   hold_req   = 1'b0;
  int   hold_left  = 0;

  dir_row_t dir_rows [9] = '{
    '{crd_pkg::TAG_MAGIC, 32'd0, CRC_GOOD, 32'h0, 8'h00, 1'b1,
      '{crd_pkg::ST_OK, crd_pkg::TAG_MAGIC, 32'd0, 32'd0, 16'd0, 1'b1,
        16'd0, 16'd0, 16'd0, 32'd0}},
    '{crd_pkg::TAG_DATA, 32'd1, CRC_GIVEN, 32'h0, 8'h00, 1'b1,
      '{crd_pkg::ST_CRC_ERR, crd_pkg::TAG_DATA, 32'd1, 32'd12, 16'd1, 1'b1,
        16'd1, 16'd0, 16'd0, 32'd1}},
    '{crd_pkg::TAG_TRCK, 32'd0, CRC_GIVEN, 32'hDEAD_BEEF, 8'h00, 1'b1,
      '{crd_pkg::ST_OK, crd_pkg::TAG_TRCK, 32'd0, 32'd25, 16'd2, 1'b1,
        16'd1, 16'd1, 16'd0, 32'd1}},
    '{32'h494E_464F, 32'd4, CRC_GOOD, 32'h0, 8'hFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'd3, CRC_GOOD, 32'h0, 8'h5A, 1'b0, '0},
    '{32'h0000_0000, 32'd2, CRC_BAD, 32'h0, 8'h00, 1'b0, '0},
    '{crd_pkg::TAG_MAGIC, 32'd1, CRC_GOOD, 32'h0, 8'h80, 1'b0, '0},
    '{32'h4354_4549, 32'd6, CRC_GOOD, 32'h0, 8'h01, 1'b0, '0},
    '{32'h5553_4552, 32'd2, CRC_BAD, 32'h0, 8'h7F, 1'b0, '0}
  };

  function automatic logic known_tag(input logic [31:0] t);
    foreach (RECORD_TAGS[i]) begin
      if (RECORD_TAGS[i] == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ crd_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic rec_t make_rec(input crd_pkg::status_t st, input logic [31:0] rtype,
                                    input logic [31:0] rlen, input logic [31:0] hoff,
                                    input logic [15:0] rnum, input logic known);
    rec_t r;
    r.status = st;
    r.rtype  = rtype;
    r.rlen   = rlen;
    r.hoff   = hoff;
    r.rnum   = rnum;
    r.known  = known;
    r.ndata  = pr_ndata;
    r.ntrck  = pr_ntrck;
    r.nunk   = pr_nunk;
    r.total  = pr_total;
    return r;
  endfunction

  function automatic rec_t close_record();
    logic [31:0]      hoff;
    crd_pkg::status_t st;
    logic             known;
    logic [32:0]      sum;
    rec_t             r;
    hoff  = pr_offset - 32'(crd_pkg::HDR_BYTES) - pr_len;
    known = known_tag(pr_type);
    st = (cfg_crc_on && pr_len != 0 && (pr_run ^ crd_pkg::ALL_ONES) != pr_crc) ?
         crd_pkg::ST_CRC_ERR : crd_pkg::ST_OK;
    if (pr_type == crd_pkg::TAG_DATA) pr_ndata = bump16(pr_ndata);
    else if (pr_type == crd_pkg::TAG_TRCK) pr_ntrck = bump16(pr_ntrck);
    else if (!known) pr_nunk = bump16(pr_nunk);
    sum = {1'b0, pr_total} + {1'b0, pr_len};
    pr_total = sum[32] ? crd_pkg::ALL_ONES : sum[31:0];
    r = make_rec(st, pr_type, pr_len, hoff, pr_index, known);
    pr_index = bump16(pr_index);
    pr_phase = PH_HDR;
    return r;
  endfunction

  // one accepted file byte; returns 1 when it closes a report
  function automatic bit deframe_byte(input logic [7:0] b, output rec_t r);
    logic [31:0] hoff;
    r = '0;
    if (pr_phase == PH_HDR) begin
      if (pr_hcount == 0 &&
          {32'h0, pr_offset} + 64'(crd_pkg::HDR_BYTES) > {32'h0, cfg_flen}) begin
        pr_phase = PH_STOP;
        if (pr_offset == 0) begin
          r = make_rec(crd_pkg::ST_SHORT, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
          return 1'b1;
        end
        return 1'b0;
      end
      if (pr_hcount < 4) pr_type = {pr_type[23:0], b};
      else if (pr_hcount < 8) pr_len = {pr_len[23:0], b};
      else pr_crc = {pr_crc[23:0], b};
      pr_hcount++;
      pr_offset++;
      if (pr_hcount < crd_pkg::HDR_BYTES) return 1'b0;
      pr_hcount = 0;
      hoff = pr_offset - 32'(crd_pkg::HDR_BYTES);
      if (pr_index == 0 && pr_type != crd_pkg::TAG_MAGIC) begin
        pr_phase = PH_STOP;
        r = make_rec(crd_pkg::ST_BAD_MAGIC, pr_type, pr_len, hoff, pr_index,
                     known_tag(pr_type));
        return 1'b1;
      end
      if ({32'h0, hoff} + 64'(crd_pkg::HDR_BYTES) + {32'h0, pr_len} >
          {32'h0, cfg_flen}) begin
        pr_phase = PH_STOP;
        r = make_rec(crd_pkg::ST_TRUNC, pr_type, pr_len, hoff, pr_index,
                     known_tag(pr_type));
        return 1'b1;
      end
      pr_run  = crd_pkg::ALL_ONES;
      pr_left = pr_len;
      if (pr_left == 0) begin
        r = close_record();
        return 1'b1;
      end
      pr_phase = PH_PAY;
      return 1'b0;
    end
    if (pr_phase == PH_PAY) begin
      pr_run = crc_step(pr_run, b);
      pr_offset++;
      if (pr_left != 0) pr_left--;
      if (pr_left == 0) begin
        r = close_record();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic cfg_access(input bit wr, input int idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input int idx, input logic [31:0] want);
    logic [31:0] got;
    cfg_access(1'b0, idx, 32'h0, got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: register %0d expected %h actual %h", $time, idx, want, got);
    end
  endtask

  task automatic set_reg(input int idx, input logic [31:0] value);
    logic [31:0] unused;
    cfg_access(1'b1, idx, value, unused);
    if (idx == crd_pkg::REG_FLEN) begin
      cfg_flen = value;
      check_reg(idx, value);
    end else begin
      cfg_crc_on = value[0];
      check_reg(idx, {31'h0, value[0]});
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input rec_t want);
    rec_t got;
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (deframe_byte(b, got)) pending_reports.push_back(typed ? want : got);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_record(input logic [31:0] rtype, input logic [31:0] rlen,
                             input byte_q_t pay, input crc_mode_e mode,
                             input logic [31:0] crc_val, input bit typed, input rec_t want);
    logic [31:0] good;
    logic [31:0] stored;
    logic [95:0] hdr;
    good = crd_pkg::ALL_ONES;
    foreach (pay[i]) good = crc_step(good, pay[i]);
    good = good ^ crd_pkg::ALL_ONES;
    case (mode)
      CRC_GOOD: stored = good;
      CRC_BAD:  stored = good ^ (32'h1 << $urandom_range(31));
      default:  stored = crc_val;
    endcase
    hdr = {rtype, rlen, stored};
    for (int i = 11; i >= 0; i--) send_byte(hdr[i*8 +: 8], typed, want);
    foreach (pay[i]) send_byte(pay[i], typed, want);
  endtask

  task automatic send_random_record();
    byte_q_t     pay;
    logic [31:0] rtype;
    int          len;
    int          pat;
    rtype = ($urandom_range(9) < 6) ? RECORD_TAGS[$urandom_range(10)] : 32'($urandom);
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(0, 20);
    pat   = $urandom_range(15);
    for (int i = 0; i < len; i++) begin
      pay.push_back((pat == 0) ? 8'h00 : (pat == 1) ? 8'hFF : 8'($urandom));
    end
    send_record(rtype, 32'(len), pay, ($urandom_range(4) == 0) ? CRC_BAD : CRC_GOOD,
                32'h0, 1'b0, '0);
  endtask

  task automatic wait_reports_done();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none actual type %h length %h", $time,
                 out_ch.record_type, out_ch.record_length);
      end else begin
        head_rec = pending_reports.pop_front();
        check_field("status", 32'(head_rec.status), 32'(out_ch.status));
        check_field("record_type", head_rec.rtype, out_ch.record_type);
        check_field("record_length", head_rec.rlen, out_ch.record_length);
        check_field("rec_offset", head_rec.hoff, out_ch.rec_offset);
        check_field("record_number", 32'(head_rec.rnum), 32'(out_ch.record_number));
        check_field("type_known", 32'(head_rec.known), 32'(out_ch.type_known));
        check_field("data_count", 32'(head_rec.ndata), 32'(out_ch.data_count));
        check_field("track_count", 32'(head_rec.ntrck), 32'(out_ch.track_count));
        check_field("unknown_count", 32'(head_rec.nunk), 32'(out_ch.unknown_count));
        check_field("payload_total", head_rec.total, out_ch.payload_total);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    byte_q_t pay;
    bit      held;
    bit      paused;
    held            = 1'b0;
    paused          = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 3'h0;
    pwdata          = 32'h0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_reg(crd_pkg::REG_FLEN, 32'h0);
    check_reg(crd_pkg::REG_CRC_EN, 32'h1);
    set_reg(crd_pkg::REG_FLEN, crd_pkg::ALL_ONES);
    set_reg(crd_pkg::REG_CRC_EN, 32'h1);

    foreach (dir_rows[i]) begin
      pay.delete();
      repeat (dir_rows[i].rlen) pay.push_back(dir_rows[i].fill);
      send_record(dir_rows[i].rtype, dir_rows[i].rlen, pay, dir_rows[i].mode,
                  dir_rows[i].crc_val, dir_rows[i].typed, dir_rows[i].want);
    end

    no_gaps = 1'b1;
    while (bytes_sent < 450) begin
      if (bytes_sent >= 280) no_gaps = 1'b0;
      if (!held && bytes_sent >= 200) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      send_random_record();
    end

    wait_reports_done();
    set_reg(crd_pkg::REG_CRC_EN, 32'h0);
    while (bytes_sent < 700) begin
      if (!paused && bytes_sent >= 580) begin
        paused = 1'b1;
        wait_reports_done();
      end
      send_random_record();
    end

    wait_reports_done();
    set_reg(crd_pkg::REG_FLEN, pr_offset + 32'd3000);
    set_reg(crd_pkg::REG_CRC_EN, 32'h1);
    while (bytes_sent < 950) send_random_record();

    // record ending exactly at the file size
    wait_reports_done();
    set_reg(crd_pkg::REG_FLEN, pr_offset + 32'd19);
    pay.delete();
    repeat (7) pay.push_back(8'($urandom));
    send_record(crd_pkg::TAG_DATA, 32'd7, pay, CRC_GOOD, 32'h0, 1'b0, '0);

    // length wraps past 2^32: truncated, parsing stops
    wait_reports_done();
    set_reg(crd_pkg::REG_FLEN, crd_pkg::ALL_ONES);
    pay.delete();
    send_record(crd_pkg::TAG_TRCK, crd_pkg::ALL_ONES, pay, CRC_GIVEN, crd_pkg::ALL_ONES,
                1'b0, '0);

    wait_reports_done();
    set_reg(crd_pkg::REG_FLEN, 32'h0);
    repeat (16) send_byte(8'($urandom), 1'b0, '0);

    wait_reports_done();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
sv/crd_pkg.sv
sv/crd_byte_if.sv
sv/crd_rec_if.sv
sv/crd_front.sv
sv/crd_fifo.sv
sv/crd_back.sv
sv/container_record_deframer_crc.sv
bench/tb_container_record_deframer_crc.sv
